// ===== hdl/frlist_pkg.sv =====
// Package for the frame replacement recency list: sizes, codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
package frlist_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

    // field widths
    localparam int MODE_W   = 2;
    localparam int IDX_W    = 6;
    localparam int PAGE_W   = 20;
    localparam int OWNER_W  = 8;
    localparam int STATUS_W = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOUCH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NEW       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EVICT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TICK_MOVE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TICK_NONE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TOUCHED   = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ALLOC_SCAN, S_ALLOC_SET, S_EV_RD, S_EV_CAP, S_EV_PG,
        S_EV_SET, S_SHDN_RD, S_SHDN_WR, S_FRONT, S_FIND_RD, S_FIND_CHK,
        S_SHUP_RD, S_SHUP_WR, S_TICK_RD
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD, PTR_ZERO, PTR_USED, PTR_USED_M1, PTR_LAST, PTR_INC, PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] { RA_PTR, RA_PTR_M1, RA_PTR_P1 } raddr_sel_t;

    typedef enum logic [1:0] { FR_HOLD, FR_PTR, FR_RDATA, FR_ZERO } frame_sel_t;

    typedef struct packed {
        logic                load_in;
        ptr_op_t             ptr_op;
        raddr_sel_t          ra_sel;
        logic                ord_wr;
        logic                ord_wr_front;
        frame_sel_t          frame_sel;
        logic                pg_wr;
        logic                old_cap;
        logic                set_valid;
        logic                clr_valid;
        logic                set_acc;
        logic                clr_acc;
        logic                used_inc;
        logic                used_dec;
        logic                code_ld;
        logic [STATUS_W-1:0] code;
        logic                res_load;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              used_zero;
        logic              used_full;
        logic              ptr_zero;
        logic              ptr_end;
        logic              ptr_last_used;
        logic              valid_ptr;
        logic              valid_frame;
        logic              match;
        logic              acc_hit;
        logic              out_free;
    } stat_t;

endpackage

// ===== hdl/frlist_dp.sv =====
// Datapath of the frame replacement recency list: recency order memory, page and
// owner memories, per-frame flags, pointer, counters and result register. Uses frlist_pkg.
module frlist_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  frlist_pkg::cmd_t                 cmd,
    output frlist_pkg::stat_t                stat,
    input  logic [frlist_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [frlist_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int FW = frlist_pkg::FRAME_W;
    localparam int CW = frlist_pkg::CNT_W;
    localparam int NF = frlist_pkg::NUM_FRAMES;

    logic [FW-1:0]                  ord_mem [NF];
    logic [frlist_pkg::PAGE_W-1:0]  page_mem [NF];
    logic [frlist_pkg::OWNER_W-1:0] owner_mem [NF];

    logic [NF-1:0] valid_reg, acc_reg;
    logic [CW-1:0] used_reg, ptr_reg, ptr_next, ptr_m1, ptr_p1;
    logic [FW-1:0] frame_reg, frame_next, ord_raddr, ord_waddr, ord_wdata, ord_rdata_reg;
    logic [frlist_pkg::MODE_W-1:0]   mode_reg;
    logic [frlist_pkg::PAGE_W-1:0]   page_reg, old_page_reg, pg_rdata_reg;
    logic [frlist_pkg::OWNER_W-1:0]  owner_reg, old_owner_reg, ow_rdata_reg;
    logic [frlist_pkg::STATUS_W-1:0] code_reg;
    logic                            m_tvalid_reg;
    logic [frlist_pkg::M_DATA_W-1:0] m_tdata_reg, res_word;
    logic [FW-1:0]                   res_frame;
    logic [frlist_pkg::PAGE_W-1:0]   res_page;
    logic [frlist_pkg::OWNER_W-1:0]  res_owner;

    assign ptr_m1 = ptr_reg - CW'(1);
    assign ptr_p1 = ptr_reg + CW'(1);

    // pointer update
    always_comb begin
        unique case (cmd.ptr_op)
            frlist_pkg::PTR_HOLD:    ptr_next = ptr_reg;
            frlist_pkg::PTR_ZERO:    ptr_next = '0;
            frlist_pkg::PTR_USED:    ptr_next = used_reg;
            frlist_pkg::PTR_USED_M1: ptr_next = used_reg - CW'(1);
            frlist_pkg::PTR_LAST:    ptr_next = CW'(NF - 1);
            frlist_pkg::PTR_INC:     ptr_next = ptr_p1;
            frlist_pkg::PTR_DEC:     ptr_next = ptr_m1;
            default:                 ptr_next = ptr_reg;
        endcase
    end

    // recency order read address
    always_comb begin
        unique case (cmd.ra_sel)
            frlist_pkg::RA_PTR:    ord_raddr = ptr_reg[FW-1:0];
            frlist_pkg::RA_PTR_M1: ord_raddr = ptr_m1[FW-1:0];
            frlist_pkg::RA_PTR_P1: ord_raddr = ptr_p1[FW-1:0];
            default:               ord_raddr = ptr_reg[FW-1:0];
        endcase
    end

    // current frame select
    always_comb begin
        unique case (cmd.frame_sel)
            frlist_pkg::FR_HOLD:  frame_next = frame_reg;
            frlist_pkg::FR_PTR:   frame_next = ptr_reg[FW-1:0];
            frlist_pkg::FR_RDATA: frame_next = ord_rdata_reg;
            frlist_pkg::FR_ZERO:  frame_next = '0;
            default:              frame_next = frame_reg;
        endcase
    end

    // front write takes the current frame, shifts copy the word just read
    assign ord_waddr = cmd.ord_wr_front ? '0 : ptr_reg[FW-1:0];
    assign ord_wdata = cmd.ord_wr_front ? frame_reg : ord_rdata_reg;

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.ord_wr) begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_rdata_reg <= ord_mem[ord_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.pg_wr) begin
            page_mem[frame_reg]  <= page_reg;
            owner_mem[frame_reg] <= owner_reg;
        end
        pg_rdata_reg <= page_mem[frame_reg];
        ow_rdata_reg <= owner_mem[frame_reg];
    end

    // control state: flags, counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            acc_reg   <= '0;
            used_reg  <= '0;
            ptr_reg   <= '0;
        end else begin
            ptr_reg <= ptr_next;
            if (cmd.set_valid) valid_reg[frame_reg] <= 1'b1;
            if (cmd.clr_valid) valid_reg[frame_reg] <= 1'b0;
            if (cmd.set_acc)   acc_reg[frame_reg]   <= 1'b1;
            if (cmd.clr_acc)   acc_reg[frame_reg]   <= 1'b0;
            if (cmd.used_inc)      used_reg <= used_reg + CW'(1);
            else if (cmd.used_dec) used_reg <= used_reg - CW'(1);
        end
    end

    // request and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg      <= s_tdata[1:0];
            frame_reg     <= s_tdata[7:2];
            page_reg      <= s_tdata[27:8];
            owner_reg     <= s_tdata[35:28];
            old_page_reg  <= '0;
            old_owner_reg <= '0;
        end else begin
            frame_reg <= frame_next;
            if (cmd.old_cap) begin
                old_page_reg  <= pg_rdata_reg;
                old_owner_reg <= ow_rdata_reg;
            end
        end
        if (cmd.code_ld) begin
            code_reg <= cmd.code;
        end
    end

    // result word
    assign res_frame = (code_reg == frlist_pkg::ST_TICK_NONE) ? '0 : frame_reg;
    assign res_page  = (code_reg == frlist_pkg::ST_EVICT) ? old_page_reg : '0;
    assign res_owner = (code_reg == frlist_pkg::ST_EVICT) ? old_owner_reg : '0;
    assign res_word  = {3'b000, res_owner, res_page, res_frame, code_reg};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_tdata_reg <= res_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // status to controller
    assign stat.mode          = mode_reg;
    assign stat.used_zero     = (used_reg == '0);
    assign stat.used_full     = (used_reg == CW'(NF));
    assign stat.ptr_zero      = (ptr_reg == '0);
    assign stat.ptr_end       = (ptr_reg == CW'(NF - 1));
    assign stat.ptr_last_used = (ptr_p1 >= used_reg);
    assign stat.valid_ptr     = valid_reg[ptr_reg[FW-1:0]];
    assign stat.valid_frame   = valid_reg[frame_reg];
    assign stat.match         = (ord_rdata_reg == frame_reg);
    assign stat.acc_hit       = acc_reg[ord_rdata_reg];
    assign stat.out_free      = !m_tvalid_reg || m_tready;

    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CW'(NF)) else $error("used count beyond pool");
    a_inc_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.used_inc |-> used_reg < CW'(NF)) else $error("allocate on full pool");
    a_dec_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.used_dec |-> used_reg != '0) else $error("free on empty pool");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> (!m_tvalid_reg || m_tready)) else $error("result overwritten");

endmodule

// ===== hdl/frlist_ctrl.sv =====
// Controller FSM of the frame replacement recency list: sequences scans and
// one-entry-per-step shifts of the recency order. Uses frlist_pkg.
module frlist_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  frlist_pkg::stat_t stat,
    output frlist_pkg::cmd_t  cmd
);

    frlist_pkg::state_t state_reg, state_next;
    logic               moved_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frlist_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            frlist_pkg::S_IDLE: begin
                if (s_tvalid) state_next = frlist_pkg::S_DECODE;
            end
            frlist_pkg::S_DECODE: begin
                unique case (stat.mode)
                    frlist_pkg::MODE_ALLOC: state_next = stat.used_full ?
                        frlist_pkg::S_EV_RD : frlist_pkg::S_ALLOC_SCAN;
                    frlist_pkg::MODE_FREE: state_next = stat.valid_frame ?
                        frlist_pkg::S_FIND_RD : frlist_pkg::S_FRONT;
                    frlist_pkg::MODE_TOUCH: state_next = frlist_pkg::S_FRONT;
                    default: state_next = stat.used_zero ?
                        frlist_pkg::S_FRONT : frlist_pkg::S_TICK_RD;
                endcase
            end
            frlist_pkg::S_ALLOC_SCAN: begin
                if (!stat.valid_ptr || stat.ptr_end) state_next = frlist_pkg::S_ALLOC_SET;
            end
            frlist_pkg::S_ALLOC_SET: state_next = frlist_pkg::S_SHDN_RD;
            frlist_pkg::S_EV_RD:     state_next = frlist_pkg::S_EV_CAP;
            frlist_pkg::S_EV_CAP:    state_next = frlist_pkg::S_EV_PG;
            frlist_pkg::S_EV_PG:     state_next = frlist_pkg::S_EV_SET;
            frlist_pkg::S_EV_SET:    state_next = frlist_pkg::S_SHDN_RD;
            frlist_pkg::S_SHDN_RD: begin
                state_next = stat.ptr_zero ? frlist_pkg::S_FRONT : frlist_pkg::S_SHDN_WR;
            end
            frlist_pkg::S_SHDN_WR:   state_next = frlist_pkg::S_SHDN_RD;
            frlist_pkg::S_FRONT: begin
                if (stat.out_free) state_next = frlist_pkg::S_IDLE;
            end
            frlist_pkg::S_FIND_RD:   state_next = frlist_pkg::S_FIND_CHK;
            frlist_pkg::S_FIND_CHK: begin
                if (stat.match) state_next = frlist_pkg::S_SHUP_RD;
                else if (stat.ptr_last_used) state_next = frlist_pkg::S_FRONT;
                else state_next = frlist_pkg::S_FIND_RD;
            end
            frlist_pkg::S_SHUP_RD: begin
                state_next = stat.ptr_last_used ? frlist_pkg::S_FRONT :
                             frlist_pkg::S_SHUP_WR;
            end
            frlist_pkg::S_SHUP_WR:   state_next = frlist_pkg::S_SHUP_RD;
            frlist_pkg::S_TICK_RD:   state_next = frlist_pkg::S_FIND_CHK;
            default:                 state_next = frlist_pkg::S_IDLE;
        endcase
        // tick shares the check state with free; its branch overrides here
        if (state_reg == frlist_pkg::S_FIND_CHK && stat.mode == frlist_pkg::MODE_TICK) begin
            if (stat.acc_hit) state_next = frlist_pkg::S_EV_SET;
            else if (stat.ptr_zero) state_next = frlist_pkg::S_FRONT;
            else state_next = frlist_pkg::S_TICK_RD;
        end
    end

    // outputs
    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        unique case (state_reg)
            frlist_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            frlist_pkg::S_DECODE: begin
                cmd.code_ld = 1'b1;
                unique case (stat.mode)
                    frlist_pkg::MODE_ALLOC: begin
                        cmd.ptr_op = stat.used_full ? frlist_pkg::PTR_LAST :
                                     frlist_pkg::PTR_ZERO;
                        cmd.code   = stat.used_full ? frlist_pkg::ST_EVICT :
                                     frlist_pkg::ST_NEW;
                    end
                    frlist_pkg::MODE_FREE: begin
                        cmd.ptr_op    = frlist_pkg::PTR_ZERO;
                        cmd.clr_valid = stat.valid_frame;
                        cmd.clr_acc   = stat.valid_frame;
                        cmd.code      = stat.valid_frame ? frlist_pkg::ST_FREED :
                                        frlist_pkg::ST_NOT_FOUND;
                    end
                    frlist_pkg::MODE_TOUCH: begin
                        cmd.set_acc = stat.valid_frame;
                        cmd.code    = stat.valid_frame ? frlist_pkg::ST_TOUCHED :
                                      frlist_pkg::ST_NOT_FOUND;
                    end
                    default: begin
                        cmd.ptr_op = frlist_pkg::PTR_USED_M1;
                        cmd.code   = frlist_pkg::ST_TICK_NONE;
                    end
                endcase
            end
            frlist_pkg::S_ALLOC_SCAN: begin
                if (!stat.valid_ptr) begin
                    cmd.frame_sel = frlist_pkg::FR_PTR;
                end else if (stat.ptr_end) begin
                    cmd.frame_sel = frlist_pkg::FR_ZERO;
                end else begin
                    cmd.ptr_op = frlist_pkg::PTR_INC;
                end
            end
            frlist_pkg::S_ALLOC_SET: begin
                cmd.set_valid = 1'b1;
                cmd.clr_acc   = 1'b1;
                cmd.pg_wr     = 1'b1;
                cmd.used_inc  = 1'b1;
                cmd.ptr_op    = frlist_pkg::PTR_USED;
            end
            frlist_pkg::S_EV_RD: begin
                cmd.ra_sel = frlist_pkg::RA_PTR;
            end
            frlist_pkg::S_EV_CAP: begin
                cmd.frame_sel = frlist_pkg::FR_RDATA;
            end
            frlist_pkg::S_EV_SET: begin
                // eviction: capture old mapping, write new one; tick hit: clear accessed flag, load tick-move code
                cmd.clr_acc = 1'b1;
                if (stat.mode == frlist_pkg::MODE_ALLOC) begin
                    cmd.old_cap = 1'b1;
                    cmd.pg_wr   = 1'b1;
                end else begin
                    cmd.code_ld = 1'b1;
                    cmd.code    = frlist_pkg::ST_TICK_MOVE;
                end
            end
            frlist_pkg::S_SHDN_RD: begin
                cmd.ra_sel = frlist_pkg::RA_PTR_M1;
            end
            frlist_pkg::S_SHDN_WR: begin
                cmd.ord_wr = 1'b1;
                cmd.ptr_op = frlist_pkg::PTR_DEC;
            end
            frlist_pkg::S_FRONT: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    // only allocate and a moving tick rewrite the front entry
                    cmd.ord_wr = (stat.mode == frlist_pkg::MODE_ALLOC) ||
                                 (stat.mode == frlist_pkg::MODE_TICK && !stat.used_zero
                                  && stat.ptr_zero && moved_reg);
                    cmd.ord_wr_front = 1'b1;
                end
            end
            frlist_pkg::S_FIND_RD: begin
                cmd.ra_sel = frlist_pkg::RA_PTR;
            end
            frlist_pkg::S_FIND_CHK: begin
                if (stat.mode == frlist_pkg::MODE_TICK) begin
                    if (stat.acc_hit) begin
                        cmd.frame_sel = frlist_pkg::FR_RDATA;
                    end else if (!stat.ptr_zero) begin
                        cmd.ptr_op = frlist_pkg::PTR_DEC;
                    end
                end else if (!stat.match && !stat.ptr_last_used) begin
                    cmd.ptr_op = frlist_pkg::PTR_INC;
                end
            end
            frlist_pkg::S_SHUP_RD: begin
                cmd.ra_sel   = frlist_pkg::RA_PTR_P1;
                cmd.used_dec = stat.ptr_last_used;
            end
            frlist_pkg::S_SHUP_WR: begin
                cmd.ord_wr = 1'b1;
                cmd.ptr_op = frlist_pkg::PTR_INC;
            end
            frlist_pkg::S_TICK_RD: begin
                cmd.ra_sel = frlist_pkg::RA_PTR;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // remembers that S_EV_SET was passed (eviction, or a tick that found an accessed frame)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moved_reg <= 1'b0;
        end else if (state_reg == frlist_pkg::S_DECODE) begin
            moved_reg <= 1'b0;
        end else if (state_reg == frlist_pkg::S_EV_SET) begin
            moved_reg <= 1'b1;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == frlist_pkg::S_IDLE) else $error("ready outside idle");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |=> state_reg == frlist_pkg::S_IDLE) else $error("result not final");
    a_front_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ord_wr && cmd.ord_wr_front) |-> cmd.res_load) else $error("stray front write");

endmodule

// ===== hdl/frame_replacement_recency_list.sv =====
// Top level of the frame replacement recency list: stream ports around the
// controller (frlist_ctrl) and datapath (frlist_dp). Uses frlist_pkg.
// Per word: touch and not-found go straight to the result; free searches, then shifts up;
// allocate scans for a free frame, then shifts down (eviction takes the last entry instead
// of the scan); tick scans from the back for an accessed frame and moves it to the front.
// One word at a time; shifts move one entry per read and write of the recency order memory port.
// Reset (aresetn low, synchronous) empties the pool; no clearing pass is needed.
module frame_replacement_recency_list (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // mode[1:0], frame_index[7:2], page_number[27:8], owner_id[35:28]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // status[2:0], result_frame[8:3], old_page[28:9], old_owner[36:29]
);

    frlist_pkg::cmd_t  cmd;
    frlist_pkg::stat_t stat;

    frlist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    frlist_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
